FILE: rtl/bpa_pkg.sv
package bpa_pkg;

    localparam int PAGES_DEF  = 4096;
    localparam int LEVELS_DEF = 6;
    localparam int ADDR_W     = 20;
    localparam int COUNT_W    = 13;
    localparam int META_W     = 8;

    localparam logic [2:0] ACT_ALLOC = 3'd0;
    localparam logic [2:0] ACT_FREE  = 3'd1;
    localparam logic [2:0] ACT_ADD   = 3'd2;
    localparam logic [2:0] ACT_SET   = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_BIG    = 2'd2;

    typedef struct packed {
        logic [2:0]         action;
        logic [ADDR_W-1:0]  page;
        logic [COUNT_W-1:0] pages;
        logic [META_W-1:0]  meta_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] page_out;
        logic [META_W-1:0] meta_out;
    } out_item_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_DECODE,
        S_A_NEXT,
        S_A_CLR,
        S_I_STEP,
        S_P_LINK,
        S_P_SET,
        S_F_PAGE,
        S_F_CHK,
        S_F_TST,
        S_M_WR,
        S_R_DATA,
        S_OUT
    } state_t;

    typedef struct packed {
        state_t op;
        logic   take;
    } cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       big;
        logic       none;
        logic       range_ok;
        logic       p_ge_lim;
        logic       cnt_done;
        logic       q_out;
        logic       chk_stop;
        logic       bit_set;
        logic       clr_last;
    } dp_stat_t;

endpackage

FILE: rtl/bpa_ctrl.sv
module bpa_ctrl import bpa_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output cmd_t     cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd.op     = state_reg;
        cmd.take   = 1'b0;
        unique case (state_reg)
            S_CLR: begin
                if (stat.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
                if (s_valid) state_next = S_DECODE;
            end
            S_DECODE: begin
                unique case (stat.action)
                    ACT_ALLOC: state_next = (stat.big || stat.none) ? S_OUT : S_A_NEXT;
                    ACT_FREE:  state_next = S_F_PAGE;
                    ACT_ADD:   state_next = stat.range_ok ? S_I_STEP : S_OUT;
                    ACT_SET:   state_next = stat.range_ok ? S_M_WR : S_OUT;
                    ACT_READ:  state_next = S_R_DATA;
                    default:   state_next = S_OUT;
                endcase
            end
            S_A_NEXT: state_next = S_A_CLR;
            S_A_CLR:  state_next = S_I_STEP;
            S_I_STEP: begin
                if (!stat.p_ge_lim) state_next = S_P_LINK;
                else if (stat.action == ACT_ALLOC) state_next = S_M_WR;
                else state_next = S_OUT;
            end
            S_P_LINK: state_next = S_P_SET;
            S_P_SET:  state_next = (stat.action == ACT_FREE) ? S_F_PAGE : S_I_STEP;
            S_F_PAGE: begin
                if (stat.cnt_done) state_next = S_OUT;
                else if (stat.q_out) state_next = S_F_PAGE;
                else state_next = S_F_CHK;
            end
            S_F_CHK:  state_next = stat.chk_stop ? S_P_LINK : S_F_TST;
            S_F_TST:  state_next = stat.bit_set ? S_F_CHK : S_P_LINK;
            S_M_WR:   state_next = stat.p_ge_lim ? S_OUT : S_M_WR;
            S_R_DATA: state_next = S_OUT;
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("accept and result at once");
    a_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_DECODE)) else $error("item not decoded");
    a_clr_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLR) |-> !s_ready) else $error("item taken during clear");
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> s_ready) else $error("no return to idle");

endmodule

FILE: rtl/bpa_dp.sv
module bpa_dp import bpa_pkg::*; #(
    parameter int PAGES  = PAGES_DEF,
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    input  in_item_t          s_data,
    input  logic              cfg_valid,
    input  logic [ADDR_W-1:0] cfg_data,
    output dp_stat_t          stat,
    output out_item_t         m_data
);

    localparam int PW = $clog2(PAGES);
    localparam int LW = $clog2(LEVELS);
    localparam logic [PW:0] NIL = (PW+1)'(PAGES);

    logic [ADDR_W-1:0]  base_reg;
    logic [2:0]         act_reg;
    logic [ADDR_W-1:0]  rel_reg;
    logic [COUNT_W-1:0] n_reg;
    logic [META_W-1:0]  meta_reg;
    logic [LW-1:0]      lvl_reg;
    logic [PW:0]        p_reg, lim_reg, blk_reg, bb_reg, h_reg;
    logic [COUNT_W-1:0] cnt_reg;
    out_item_t          res_reg;
    logic [PW:0]        head_reg [LEVELS];

    logic [LEVELS-1:0]  free_mem [PAGES];
    logic [PW:0]        next_mem [PAGES];
    logic [PW:0]        prev_mem [PAGES];
    logic [META_W-1:0]  meta_mem [PAGES];
    logic [LEVELS-1:0]  fm_rd_reg;
    logic [PW:0]        nx_rd_reg, pv_rd_reg;
    logic [META_W-1:0]  mt_rd_reg;

    logic [COUNT_W-1:0] need;
    logic               big, found;
    logic [LW-1:0]      lf, sel, al, ft, lsel;
    logic [PW:0]        span, b, mask, lvl_bit_p;
    logic [ADDR_W-1:0]  q;
    logic               q_out, in_range, chk_stop, bit_set, p_ge_lim;
    logic [ADDR_W:0]    sum;
    logic [PW:0]        rng_lim;
    logic [LEVELS-1:0]  lvl_bit;

    logic              fm_we, nx_we, pv_we, mt_we;
    logic [PW-1:0]     fm_wa, fm_ra, nx_wa, nx_ra, pv_wa, rd_a, mt_a;
    logic [LEVELS-1:0] fm_wd;
    logic [PW:0]       nx_wd, pv_wd;

    always_comb begin
        need = (n_reg == '0) ? COUNT_W'(1) : n_reg;
        big  = 32'(need) > (32'(1) << (LEVELS - 1));
        lf   = LW'(LEVELS - 1);
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if ((32'(1) << l) >= 32'(need)) lf = LW'(l);
        end
        found = 1'b0;
        sel   = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (LW'(l) >= lf && head_reg[l] != NIL) begin
                found = 1'b1;
                sel   = LW'(l);
            end
        end
        al = LW'(LEVELS - 1);
        for (int l = LEVELS - 2; l >= 0; l--) begin
            if (p_reg[l]) al = LW'(l);
        end
        span = lim_reg - p_reg;
        ft   = '0;
        for (int l = 1; l < LEVELS; l++) begin
            if ((32'(1) << l) <= 32'(span)) ft = LW'(l);
        end
        lsel      = (al < ft) ? al : ft;
        q         = rel_reg + ADDR_W'(cnt_reg);
        q_out     = {1'b0, q} >= (ADDR_W+1)'(PAGES);
        in_range  = {1'b0, rel_reg} < (ADDR_W+1)'(PAGES);
        sum       = (ADDR_W+1)'(rel_reg) + (ADDR_W+1)'(n_reg);
        rng_lim   = (sum > (ADDR_W+1)'(PAGES)) ? NIL : sum[PW:0];
        lvl_bit_p = (PW+1)'(1) << lvl_reg;
        b         = p_reg ^ lvl_bit_p;
        mask      = ((PW+1)'(2) << lvl_reg) - (PW+1)'(1);
        chk_stop  = (lvl_reg == LW'(LEVELS - 1)) || (b >= NIL);
        lvl_bit   = LEVELS'(1) << lvl_reg;
        bit_set   = fm_rd_reg[lvl_reg];
        p_ge_lim  = p_reg >= lim_reg;
    end

    always_comb begin
        stat.action   = act_reg;
        stat.big      = big;
        stat.none     = !found;
        stat.range_ok = in_range && (n_reg != '0);
        stat.p_ge_lim = p_ge_lim;
        stat.cnt_done = cnt_reg == n_reg;
        stat.q_out    = q_out;
        stat.chk_stop = chk_stop;
        stat.bit_set  = bit_set;
        stat.clr_last = p_reg == (PW+1)'(PAGES - 1);
        m_data        = res_reg;
    end

    always_comb begin
        fm_we = 1'b0;
        fm_wa = p_reg[PW-1:0];
        fm_wd = fm_rd_reg | lvl_bit;
        fm_ra = p_reg[PW-1:0];
        nx_we = 1'b0;
        nx_wa = p_reg[PW-1:0];
        nx_wd = head_reg[lvl_reg];
        nx_ra = b[PW-1:0];
        pv_we = 1'b0;
        pv_wa = p_reg[PW-1:0];
        pv_wd = NIL;
        rd_a  = b[PW-1:0];
        mt_we = 1'b0;
        mt_a  = rel_reg[PW-1:0];
        unique case (cmd.op)
            S_CLR: begin
                fm_we = 1'b1;
                fm_wd = '0;
            end
            S_DECODE: nx_ra = head_reg[sel][PW-1:0];
            S_A_NEXT: begin
                fm_ra = blk_reg[PW-1:0];
                pv_we = nx_rd_reg < NIL;
                pv_wa = nx_rd_reg[PW-1:0];
            end
            S_A_CLR: begin
                fm_we = 1'b1;
                fm_wa = blk_reg[PW-1:0];
                fm_wd = fm_rd_reg & ~lvl_bit;
            end
            S_P_LINK: begin
                nx_we = 1'b1;
                pv_we = 1'b1;
            end
            S_P_SET: begin
                fm_we = 1'b1;
                pv_we = h_reg < NIL;
                pv_wa = h_reg[PW-1:0];
                pv_wd = p_reg;
            end
            S_F_CHK: fm_ra = b[PW-1:0];
            S_F_TST: begin
                fm_we = bit_set;
                fm_wa = bb_reg[PW-1:0];
                fm_wd = fm_rd_reg & ~lvl_bit;
                nx_we = bit_set && (pv_rd_reg < NIL);
                nx_wa = pv_rd_reg[PW-1:0];
                nx_wd = nx_rd_reg;
                pv_we = bit_set && (nx_rd_reg < NIL);
                pv_wa = nx_rd_reg[PW-1:0];
                pv_wd = pv_rd_reg;
            end
            S_M_WR: begin
                mt_we = !p_ge_lim;
                mt_a  = p_reg[PW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (fm_we) free_mem[fm_wa] <= fm_wd;
        fm_rd_reg <= free_mem[fm_ra];
        if (nx_we) next_mem[nx_wa] <= nx_wd;
        nx_rd_reg <= next_mem[nx_ra];
        if (pv_we) prev_mem[pv_wa] <= pv_wd;
        pv_rd_reg <= prev_mem[rd_a];
        if (mt_we) meta_mem[mt_a] <= meta_reg;
        mt_rd_reg <= meta_mem[mt_a];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            p_reg    <= '0;
            for (int l = 0; l < LEVELS; l++) head_reg[l] <= NIL;
        end else begin
            if (cfg_valid) base_reg <= cfg_data;
            unique case (cmd.op)
                S_CLR: p_reg <= p_reg + (PW+1)'(1);
                S_DECODE: begin
                    if (act_reg == ACT_ALLOC && !big && found) p_reg <= head_reg[sel];
                    else p_reg <= rel_reg[PW:0];
                end
                S_A_NEXT: head_reg[lvl_reg] <= nx_rd_reg;
                S_A_CLR:  p_reg <= blk_reg + (PW+1)'(need);
                S_I_STEP: begin
                    if (p_ge_lim) p_reg <= blk_reg;
                end
                S_P_LINK: head_reg[lvl_reg] <= p_reg;
                S_P_SET: begin
                    if (act_reg != ACT_FREE) p_reg <= p_reg + lvl_bit_p;
                end
                S_F_PAGE: begin
                    if (cnt_reg != n_reg && !q_out) p_reg <= q[PW:0];
                end
                S_F_TST: begin
                    if (bit_set) begin
                        if (pv_rd_reg >= NIL) head_reg[lvl_reg] <= nx_rd_reg;
                        p_reg <= p_reg & ~mask;
                    end
                end
                S_M_WR: begin
                    if (!p_ge_lim) p_reg <= p_reg + (PW+1)'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            S_IDLE: begin
                if (cmd.take) begin
                    act_reg  <= s_data.action;
                    rel_reg  <= s_data.page - base_reg;
                    n_reg    <= s_data.pages;
                    meta_reg <= s_data.meta_in;
                end
            end
            S_DECODE: begin
                res_reg <= '0;
                cnt_reg <= '0;
                lim_reg <= rng_lim;
                if (act_reg == ACT_ALLOC) begin
                    if (big) res_reg.status <= ST_BIG;
                    else if (!found) res_reg.status <= ST_NOFREE;
                    blk_reg <= head_reg[sel];
                    lvl_reg <= sel;
                end
            end
            S_A_NEXT: res_reg.page_out <= base_reg + ADDR_W'(blk_reg);
            S_A_CLR:  lim_reg <= blk_reg + lvl_bit_p;
            S_I_STEP: begin
                if (!p_ge_lim) lvl_reg <= lsel;
                else lim_reg <= blk_reg + (PW+1)'(need);
            end
            S_P_LINK: h_reg <= head_reg[lvl_reg];
            S_P_SET: begin
                if (act_reg == ACT_FREE) cnt_reg <= cnt_reg + COUNT_W'(1);
            end
            S_F_PAGE: begin
                if (cnt_reg != n_reg) begin
                    if (q_out) cnt_reg <= cnt_reg + COUNT_W'(1);
                    else lvl_reg <= '0;
                end
            end
            S_F_CHK: bb_reg <= b;
            S_F_TST: begin
                if (bit_set) lvl_reg <= lvl_reg + LW'(1);
            end
            S_R_DATA: begin
                if (in_range) res_reg.meta_out <= mt_rd_reg;
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/buddy_page_allocator_unit.sv
// channel | direction | handshake          | payload
// s_      | in        | s_valid / s_ready  | s_data (action, page, pages, meta_in)
// m_      | out       | m_valid / m_ready  | m_data (status, page_out, meta_out)
// cfg_    | in        | cfg_valid/cfg_ready| cfg_data (base_page)
// one item at a time; a controller walks a datapath built around block memories
// allocate: 5 + need + 3 per tail block cycles; free: 2 + per page 5 + 2 per merge, 1 if outside
// add range: 2 + 3 per block; set range: 2 + pages cycles, up to a few thousand; read: 2
// after reset a clearing pass of PAGES cycles sweeps the free bitmap, s_ready low
// a result waits in its register while m_ready is low; no new item until it is taken
module buddy_page_allocator_unit import bpa_pkg::*; #(
    parameter int PAGES  = PAGES_DEF,
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ADDR_W-1:0] cfg_data
);

    cmd_t     cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    bpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bpa_dp #(
        .PAGES  (PAGES),
        .LEVELS (LEVELS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .m_data    (m_data)
    );

endmodule

FILE: test/bpa_predict_check.sv
module bpa_predict_check import bpa_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  in_item_t          s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  out_item_t         m_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [ADDR_W-1:0] cfg_data,
    output int                errors,
    output int                pending
);

    localparam int NP = PAGES_DEF;
    localparam int NL = LEVELS_DEF;

    bit               free_map[NL][NP];
    int unsigned      link_nxt[NP];
    int unsigned      link_prv[NP];
    int unsigned      lvl_head[NL];
    logic [META_W-1:0] meta_store[NP];
    logic [ADDR_W-1:0] base_pg;
    out_item_t        awaited[$];

    initial begin
        errors = 0;
        pending = 0;
    end

    function automatic void clear_model();
        for (int l = 0; l < NL; l++) begin
            lvl_head[l] = NP;
            for (int p = 0; p < NP; p++) free_map[l][p] = 0;
        end
        for (int p = 0; p < NP; p++) begin
            link_nxt[p] = 0;
            link_prv[p] = 0;
            meta_store[p] = '0;
        end
        base_pg = '0;
    endfunction

    function automatic void link_front(int l, int unsigned p);
        int unsigned h;
        h = lvl_head[l];
        link_prv[p] = NP;
        link_nxt[p] = h;
        if (h < NP) link_prv[h] = p;
        lvl_head[l] = p;
    endfunction

    function automatic void unlink(int l, int unsigned p);
        int unsigned pr, nx;
        pr = link_prv[p];
        nx = link_nxt[p];
        if (pr < NP) link_nxt[pr] = nx;
        else lvl_head[l] = nx;
        if (nx < NP) link_prv[nx] = pr;
    endfunction

    function automatic int blk_align(int unsigned p);
        int l;
        l = 0;
        if (p == 0) return NL - 1;
        while (l < NL - 1 && ((p >> l) & 1) == 0) l++;
        return l;
    endfunction

    function automatic int blk_fit(int unsigned n);
        int l;
        l = 0;
        while (l < NL - 1 && (2 << l) <= n) l++;
        return l;
    endfunction

    function automatic void mark_free_range(int unsigned start, int unsigned limit);
        int unsigned p;
        int a, f, l;
        p = start;
        while (p < limit) begin
            a = blk_align(p);
            f = blk_fit(limit - p);
            l = a < f ? a : f;
            link_front(l, p);
            free_map[l][p >> l] = 1;
            p += 1 << l;
        end
    endfunction

    function automatic void release_page(int unsigned p_in);
        int unsigned p, b;
        int l;
        p = p_in;
        l = 0;
        while (l < NL - 1) begin
            b = p ^ (1 << l);
            if (b >= NP || free_map[l][b >> l] == 0) break;
            free_map[l][b >> l] = 0;
            unlink(l, b);
            p &= ~((2 << l) - 1);
            l++;
        end
        link_front(l, p);
        free_map[l][p >> l] = 1;
    endfunction

    function automatic out_item_t predict(in_item_t it);
        out_item_t r;
        logic [ADDR_W-1:0] rel, q;
        bit in_blk;
        int unsigned n, need, p, nx, limit;
        int l;
        r = '0;
        rel = it.page - base_pg;
        in_blk = rel < NP;
        n = it.pages;
        case (it.action)
            ACT_ALLOC: begin
                need = n == 0 ? 1 : n;
                if (need > (1 << (NL - 1))) begin
                    r.status = ST_BIG;
                end else begin
                    l = 0;
                    while ((1 << l) < need) l++;
                    while (l < NL && lvl_head[l] >= NP) l++;
                    if (l >= NL) begin
                        r.status = ST_NOFREE;
                    end else begin
                        p = lvl_head[l];
                        nx = link_nxt[p];
                        lvl_head[l] = nx;
                        if (nx < NP) link_prv[nx] = NP;
                        free_map[l][p >> l] = 0;
                        mark_free_range(p + need, p + (1 << l));
                        for (int i = 0; i < need; i++) meta_store[p + i] = it.meta_in;
                        r.page_out = base_pg + p[ADDR_W-1:0];
                    end
                end
            end
            ACT_FREE: begin
                for (int i = 0; i < n; i++) begin
                    q = rel + i[ADDR_W-1:0];
                    if (q < NP) release_page(q);
                end
            end
            ACT_ADD, ACT_SET: begin
                if (in_blk && n > 0) begin
                    limit = (NP - rel < n) ? NP : rel + n;
                    if (it.action == ACT_ADD) mark_free_range(rel, limit);
                    else for (int unsigned i = rel; i < limit; i++) meta_store[i] = it.meta_in;
                end
            end
            ACT_READ: begin
                if (in_blk) r.meta_out = meta_store[rel];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    initial clear_model();

    always @(posedge aclk) begin
        out_item_t w;
        if (!aresetn) begin
            clear_model();
            awaited.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (awaited.size() == 0) begin
                    report("unexpected item", m_data, 0);
                end else begin
                    w = awaited.pop_front();
                    if (m_data.status !== w.status) report("status", m_data.status, w.status);
                    if (m_data.page_out !== w.page_out)
                        report("page_out", m_data.page_out, w.page_out);
                    if (m_data.meta_out !== w.meta_out)
                        report("meta_out", m_data.meta_out, w.meta_out);
                end
            end
            if (s_valid && s_ready) awaited.push_back(predict(s_data));
            if (cfg_valid && cfg_ready) base_pg = cfg_data;
        end
        pending = awaited.size();
    end

    final begin
        if (awaited.size() != 0) $display("items still awaited: %0d", awaited.size());
    end

endmodule

FILE: test/testbench.sv
module testbench;
    import bpa_pkg::*;

    localparam int NP = PAGES_DEF;
    localparam int RESERVE_END = NP - 6;

    typedef struct {
        int rel;
        int n;
    } owned_blk_t;

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              s_valid = 0;
    logic              s_ready;
    in_item_t          s_data = '0;
    logic              m_valid;
    logic              m_ready;
    out_item_t         m_data;
    logic              cfg_valid = 0;
    logic              cfg_ready;
    logic [ADDR_W-1:0] cfg_data = '0;
    int                errors;
    int                pending;

    bit                calm = 0;
    logic [ADDR_W-1:0] base_now = '0;
    owned_blk_t        owned[$];
    int                reserve_at = 0;
    out_item_t         last_res;

    always #5 aclk = ~aclk;

    buddy_page_allocator_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    bpa_predict_check u_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always begin
        m_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge aclk);
        if (!calm) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    end

    initial begin
        #50000000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic send(logic [2:0] a, logic [ADDR_W-1:0] pg, logic [COUNT_W-1:0] n,
                        logic [META_W-1:0] m);
        in_item_t it;
        it.action = a;
        it.page = pg;
        it.pages = n;
        it.meta_in = m;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
    endtask

    task automatic send_rel(logic [2:0] a, int rel, int n, logic [META_W-1:0] m);
        send(a, base_now + rel[ADDR_W-1:0], n[COUNT_W-1:0], m);
    endtask

    task automatic grab(int n);
        owned_blk_t b;
        send_rel(ACT_ALLOC, $urandom, n, $urandom);
        s_valid <= 1'b0;
        do @(negedge aclk); while (!(m_valid && m_ready && pending == 1));
        last_res = m_data;
        @(posedge aclk);
        if (last_res.status == ST_OK) begin
            b.rel = int'(last_res.page_out - base_now);
            b.n = n == 0 ? 1 : n;
            owned.push_back(b);
        end
    endtask

    task automatic give_back();
        int k;
        k = $urandom_range(0, owned.size() - 1);
        send_rel(ACT_FREE, owned[k].rel, owned[k].n, $urandom);
        owned.delete(k);
    endtask

    task automatic add_chunk();
        int n;
        n = $urandom_range(1, 64);
        if (n > RESERVE_END - reserve_at) n = RESERVE_END - reserve_at;
        send_rel(ACT_ADD, reserve_at, n, $urandom);
        reserve_at += n;
    endtask

    task automatic set_base(logic [ADDR_W-1:0] v);
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (2000) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        base_now = v;
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30 || (r < 55 && owned.size() == 0)) begin
            grab($urandom_range(0, 99) < 85 ? $urandom_range(0, 12) : $urandom_range(13, 32));
        end else if (r < 55) begin
            give_back();
        end else if (r < 65 && reserve_at < RESERVE_END) begin
            add_chunk();
        end else if (r < 75) begin
            send_rel(ACT_SET, $urandom_range(0, NP + 50), $urandom_range(0, 80), $urandom);
        end else if (r < 90) begin
            send_rel(ACT_READ, $urandom_range(0, NP + 20), $urandom, $urandom);
        end else begin
            case ($urandom_range(0, 4))
                0: send($urandom_range(5, 7), $urandom, $urandom, $urandom);
                1: send_rel(ACT_ALLOC, $urandom, $urandom_range(33, 8191), $urandom);
                2: send_rel(ACT_FREE, $urandom_range(NP, NP + 100), $urandom, $urandom);
                3: send_rel(ACT_ADD, $urandom_range(NP, (1 << ADDR_W) - 1), $urandom,
                            $urandom);
                default: send(ACT_READ, $urandom, $urandom, $urandom);
            endcase
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] bases [4];
        bases = '{20'h00000, 20'hFFFFF, 20'h00000, 20'hFFF80};
        bases[2] = $urandom;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        set_base(bases[0]);

        send_rel(ACT_READ, NP, 0, 8'h00);
        send_rel(ACT_SET, 0, 8191, 8'hA5);
        grab(0);
        send_rel(ACT_ALLOC, 0, 33, 8'hFF);
        send_rel(ACT_ALLOC, 0, 8191, 8'hFF);
        send_rel(ACT_ADD, 0, 0, 8'h00);
        send_rel(ACT_ADD, 5000, 40, 8'h00);
        send_rel(ACT_ADD, 0, 64, 8'h00);
        reserve_at = 64;
        grab(0);
        grab(32);
        grab(3);
        grab(5);
        send_rel(ACT_READ, owned[1].rel, 0, 8'h00);
        while (owned.size() > 0) give_back();
        send_rel(ACT_FREE, 7, 0, 8'h00);
        send_rel(ACT_FREE, NP, 8191, 8'h00);
        send(3'd5, 20'hFFFFF, 13'h1FFF, 8'hFF);
        send(3'd7, 20'h00000, 13'h0000, 8'h00);
        send_rel(ACT_SET, NP + 3, 10, 8'h3C);
        send_rel(ACT_SET, NP - 3, 100, 8'h5A);
        send_rel(ACT_ADD, RESERVE_END, 100, 8'h00);
        send_rel(ACT_READ, 0, 0, 8'h00);
        send_rel(ACT_READ, NP - 1, 0, 8'h00);
        grab(32);

        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0) set_base(bases[ph]);
            for (int i = 0; i < 170; i++) begin
                if (ph == 3 && i >= 90) calm = 1;
                random_item();
            end
        end

        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (2000) @(posedge aclk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/bpa_pkg.sv
rtl/bpa_ctrl.sv
rtl/bpa_dp.sv
rtl/buddy_page_allocator_unit.sv
test/bpa_predict_check.sv
test/testbench.sv
